// ===== rtl/core/ftt_pkg.sv =====
// Package for the firmware object transfer tracker.
// Holds the payload structs, counter state, configuration, command and status codes.
// No dependencies.
`default_nettype none

package ftt_pkg;

  localparam int unsigned FttMaxObjectBytes = 4096;
  localparam int unsigned FttCntW = 32;
  localparam int unsigned FttCfgIdxW = 1;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_EXECUTE = 2'd2,
    CMD_UNUSED  = 2'd3
  } ftt_cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OBJECT = 2'd1,
    ST_BAD_PARAM  = 2'd2,
    ST_NO_ROOM    = 2'd3
  } ftt_status_e;

  localparam logic [FttCfgIdxW-1:0] CFG_TOTAL_SIZE = 1'd0;
  localparam logic [FttCfgIdxW-1:0] CFG_AUTH       = 1'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic [FttCntW-1:0] length;
  } ftt_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FttCntW-1:0] image_offset;
    logic [FttCntW-1:0] object_base;
    logic [FttCntW-1:0] object_length;
    logic [FttCntW-1:0] object_filled;
  } ftt_out_t;

  typedef struct packed {
    logic [FttCntW-1:0] offset;
    logic [FttCntW-1:0] base;
    logic [FttCntW-1:0] size;
    logic [FttCntW-1:0] filled;
  } ftt_state_t;

  typedef struct packed {
    logic [FttCntW-1:0] total_size;
    logic               auth;
  } ftt_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftt_cmd_unit.sv =====
// Command evaluator: checks one create, write or execute transaction
// against the counters and gives the status and the next counters.
// Depends on ftt_pkg.
`default_nettype none

module ftt_cmd_unit import ftt_pkg::*; #(
  parameter int unsigned MaxObjectBytes = FttMaxObjectBytes
) (
  input  ftt_in_t     cmd_i,
  input  ftt_cfg_t    cfg_i,
  input  ftt_state_t  state_i,
  output ftt_state_t  state_o,
  output ftt_status_e status_o
);

  logic [FttCntW-1:0] room;
  logic [FttCntW-1:0] obj_left;

  assign room     = cfg_i.total_size - state_i.offset;
  assign obj_left = state_i.size - state_i.filled;

  always_comb begin
    state_o  = state_i;
    status_o = ST_BAD_PARAM;
    case (ftt_cmd_e'(cmd_i.command))
      CMD_CREATE: begin
        if (!cfg_i.auth) begin
          status_o = ST_BAD_OBJECT;
        end else if (cmd_i.length == '0 ||
                     cmd_i.length > FttCntW'(MaxObjectBytes) ||
                     state_i.offset > cfg_i.total_size) begin
          status_o = ST_BAD_PARAM;
        end else if (cmd_i.length > room) begin
          status_o = ST_NO_ROOM;
        end else begin
          status_o       = ST_OK;
          state_o.base   = state_i.offset;
          state_o.size   = cmd_i.length;
          state_o.filled = '0;
        end
      end
      CMD_WRITE: begin
        if (!cfg_i.auth || cmd_i.length == '0) begin
          status_o = ST_BAD_PARAM;
        end else if (state_i.filled > state_i.size) begin
          status_o = ST_BAD_OBJECT;
        end else if (cmd_i.length > obj_left || cmd_i.length > room) begin
          status_o = ST_NO_ROOM;
        end else begin
          status_o       = ST_OK;
          state_o.filled = state_i.filled + cmd_i.length;
          state_o.offset = state_i.offset + cmd_i.length;
        end
      end
      CMD_EXECUTE: begin
        if (state_i.size == '0 || state_i.filled != state_i.size) begin
          status_o = ST_BAD_OBJECT;
        end else begin
          status_o       = ST_OK;
          state_o.base   = state_i.offset;
          state_o.size   = '0;
          state_o.filled = '0;
        end
      end
      default: begin
        status_o = ST_BAD_PARAM;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ftt_out_buf.sv =====
// Output register with a skid stage for result transactions.
// Depends on ftt_pkg.
`default_nettype none

module ftt_out_buf import ftt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ftt_out_t push_data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ftt_out_t out_data_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  ftt_out_t out_data_q, out_data_d;
  ftt_out_t skid_data_q, skid_data_d;
  logic     pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_valid_d = 1'b1;
        skid_data_d  = push_data_i;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = skid_data_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = push_i;
      out_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/firmware_object_transfer_tracker.sv =====
// Top level of the firmware object transfer tracker.
// Depends on ftt_pkg, ftt_cmd_unit and ftt_out_buf.
//
// Takes one create, write or execute transaction per cycle while not
// stalled and returns one result (status and the four counters after the
// command) per transaction. The counters update at the edge that accepts
// the transaction, so the next command may follow in the very next cycle.
// The result sits in an output register backed by a one-deep skid stage;
// input stall rises only when both hold an untaken result. Configuration
// writes (image size, authenticated flag) take effect at the next edge.
`default_nettype none

module firmware_object_transfer_tracker import ftt_pkg::*; #(
  parameter int unsigned MaxObjectBytes = FttMaxObjectBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [FttCfgIdxW-1:0] cfg_idx_i,
  input  logic [FttCntW-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ftt_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ftt_out_t              out_data_o
);

  ftt_cfg_t    cfg_q, cfg_d;
  ftt_state_t  state_q, state_next;
  ftt_status_e status;
  ftt_out_t    result;
  logic        accept;
  logic        buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL_SIZE: cfg_d.total_size = cfg_wdata_i;
        CFG_AUTH:       cfg_d.auth       = cfg_wdata_i[0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  ftt_cmd_unit #(
    .MaxObjectBytes(MaxObjectBytes)
  ) u_cmd (
    .cmd_i   (in_data_i),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_next),
    .status_o(status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      state_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      if (accept) begin
        state_q <= state_next;
      end
    end
  end

  always_comb begin
    result.status        = status;
    result.image_offset  = state_next.offset;
    result.object_base   = state_next.base;
    result.object_length = state_next.size;
    result.object_filled = state_next.filled;
  end

  ftt_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(result),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
